// ----- rtl/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and codes for the bounded stack: item formats, commands,
// result status codes, datapath operations and controller states.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int WORD_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_SHOW = 2'd2;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_POPPED    = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_SHOWN     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_OVERFLOW,
    OP_UNDERFLOW,
    OP_EMPTY,
    OP_POP_RD,
    OP_POP_OUT,
    OP_SHOW_RD,
    OP_SHOW_OUT
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_zero;
  } dp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SHOW
  } ctl_state_t;

endpackage

// ----- rtl/bls_ctrl.sv -----
// ----------------------------------------------------------------------------
// bls_ctrl
// Controller for the bounded stack: decodes accepted commands, sequences
// the pop read and the top-to-bottom show walk, and drives busy.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          cmd,
  input  bls_pkg::dp_status_t status,
  output bls_pkg::dp_op_t     op,
  output logic                busy
);

  bls_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = bls_pkg::OP_NONE;
    busy      = 1'b1;
    case (state_r)
      bls_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (cmd)
            bls_pkg::CMD_PUSH: begin
              op = status.full ? bls_pkg::OP_OVERFLOW : bls_pkg::OP_PUSH;
            end
            bls_pkg::CMD_POP: begin
              if (status.empty) begin
                op = bls_pkg::OP_UNDERFLOW;
              end else begin
                op        = bls_pkg::OP_POP_RD;
                state_nxt = bls_pkg::S_POP;
              end
            end
            bls_pkg::CMD_SHOW: begin
              if (status.empty) begin
                op = bls_pkg::OP_EMPTY;
              end else begin
                op        = bls_pkg::OP_SHOW_RD;
                state_nxt = bls_pkg::S_SHOW;
              end
            end
            default: begin
              op = bls_pkg::OP_NONE;
            end
          endcase
        end
      end
      bls_pkg::S_POP: begin
        op        = bls_pkg::OP_POP_OUT;
        state_nxt = bls_pkg::S_IDLE;
      end
      bls_pkg::S_SHOW: begin
        op = bls_pkg::OP_SHOW_OUT;
        if (status.ptr_zero) begin
          state_nxt = bls_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bls_pkg::S_IDLE;
      end
    endcase
  end

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bls_pkg::S_POP |=> state_r == bls_pkg::S_IDLE)
    else $error("pop sequence overstayed");

  a_show_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bls_pkg::S_IDLE && state_nxt == bls_pkg::S_SHOW) |-> !status.empty)
    else $error("show walk started on empty stack");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> state_r == bls_pkg::S_IDLE && $past(state_nxt) == bls_pkg::S_IDLE)
    else $error("busy dropped outside idle");

endmodule

// ----- rtl/bls_dp.sv -----
// ----------------------------------------------------------------------------
// bls_dp
// Datapath for the bounded stack: entry memory with registered read,
// entry count, show pointer, capacity register and result register.
// ----------------------------------------------------------------------------
module bls_dp #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bls_pkg::dp_op_t                  op,
  input  logic signed [bls_pkg::WORD_W-1:0] push_value,
  input  logic                             cfg_we,
  input  logic [bls_pkg::CAP_W-1:0]        cfg_wdata,
  output bls_pkg::dp_status_t              status,
  output logic                             out_valid,
  output bls_pkg::out_item_t               out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bls_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bls_pkg::WORD_W-1:0] rd_data_r;

  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [bls_pkg::CAP_W-1:0]  cap_r;
  logic                       out_valid_r, out_valid_nxt;
  bls_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [CW-1:0]              cnt_dec;
  logic [AW-1:0]              ptr_dec;
  logic [bls_pkg::CAP_W-1:0]  cap_eff;
  logic [bls_pkg::CAP_W-1:0]  count_ext;
  logic                       wr_en, rd_en;
  logic [AW-1:0]              rd_addr;

  assign cnt_dec   = count_r - CW'(1);
  assign ptr_dec   = ptr_r - AW'(1);
  assign count_ext = bls_pkg::CAP_W'(count_r);

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = bls_pkg::CAP_W'(1);
    end else if (cap_r > bls_pkg::CAP_W'(DEPTH)) begin
      cap_eff = bls_pkg::CAP_W'(DEPTH);
    end
  end

  assign status.full     = count_ext >= cap_eff;
  assign status.empty    = count_r == '0;
  assign status.ptr_zero = ptr_r == '0;

  always_comb begin
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cnt_dec[AW-1:0];
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (op)
      bls_pkg::OP_PUSH: begin
        wr_en         = 1'b1;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_PUSHED, data: push_value, last: 1'b1};
      end
      bls_pkg::OP_OVERFLOW: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_OVERFLOW, data: '0, last: 1'b1};
      end
      bls_pkg::OP_UNDERFLOW: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_UNDERFLOW, data: '0, last: 1'b1};
      end
      bls_pkg::OP_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_EMPTY, data: '0, last: 1'b1};
      end
      bls_pkg::OP_POP_RD: begin
        rd_en     = 1'b1;
        count_nxt = cnt_dec;
      end
      bls_pkg::OP_POP_OUT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_POPPED, data: rd_data_r, last: 1'b1};
      end
      bls_pkg::OP_SHOW_RD: begin
        rd_en   = 1'b1;
        ptr_nxt = cnt_dec[AW-1:0];
      end
      bls_pkg::OP_SHOW_OUT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: bls_pkg::ST_SHOWN, data: rd_data_r,
                          last: status.ptr_zero};
        if (!status.ptr_zero) begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec;
          ptr_nxt = ptr_dec;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= bls_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_ext <= bls_pkg::CAP_W'(DEPTH))
    else $error("entry count beyond depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    op == bls_pkg::OP_PUSH |-> !status.full)
    else $error("push written into full stack");

  a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == bls_pkg::OP_POP_RD || op == bls_pkg::OP_SHOW_RD) |-> !status.empty)
    else $error("read issued on empty stack");

  a_show_count_held: assert property (@(posedge clk) disable iff (!rst_n)
    op == bls_pkg::OP_SHOW_OUT |-> $stable(count_r))
    else $error("count moved during show walk");

endmodule

// ----- rtl/bounded_lifo_stack.sv -----
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Last-in first-out stack of signed 32-bit words with programmable capacity.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each result is
// shown for exactly one cycle with out_valid high and cannot be held off.
// Push, overflow, underflow and an empty show give their result in the
// cycle after acceptance and a new item may follow at once (one per cycle).
// A pop keeps busy high for one cycle while the entry memory, which has a
// registered read port, returns the top word, which then passes through
// the result register. A show keeps busy high for the whole walk and
// gives one entry per cycle, top first, each read and then registered,
// with last set on the bottom entry. Capacity writes apply to the next
// command and values outside 1..DEPTH are saturated.
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  bls_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output bls_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [bls_pkg::CAP_W-1:0] cfg_wdata
);

  bls_pkg::dp_op_t     op;
  bls_pkg::dp_status_t status;

  bls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (in_item.cmd),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  bls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .push_value (in_item.push_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
